FILE: src/swmf_pkg.sv
package swmf_pkg;

    localparam int WINDOW_MAX = 32;
    localparam int NUM_VALUES = 6;

    localparam int VAL_W  = 3;   // sample and mode field width
    localparam int LEN_W  = 6;   // window_len register width
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int PTR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CMP_W  = (LEN_W > CNT_W) ? LEN_W : CNT_W;
    localparam int IDX_W  = $clog2(NUM_VALUES);

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);

    typedef struct packed {
        logic             en;
        logic             drop;
        logic [IDX_W-1:0] old_val;
        logic [IDX_W-1:0] new_val;
    } t_hist_upd;

endpackage

FILE: src/swmf_in_if.sv
interface swmf_in_if;
    logic                         valid;
    logic                         ready;
    logic [swmf_pkg::VAL_W-1:0]   lane_count;

    modport source (output valid, output lane_count, input ready);
    modport sink   (input valid, input lane_count, output ready);
endinterface

FILE: src/swmf_out_if.sv
interface swmf_out_if;
    logic                         valid;
    logic                         ready;
    logic [swmf_pkg::VAL_W-1:0]   mode_value;

    modport source (output valid, output mode_value, input ready);
    modport sink   (input valid, input mode_value, output ready);
endinterface

FILE: src/swmf_cell.sv
module swmf_cell (
    input  logic                            i_clk,
    input  logic                            i_shift,
    input  logic [swmf_pkg::IDX_W-1:0]      i_data,
    output logic [swmf_pkg::IDX_W-1:0]      o_data
);

    logic [swmf_pkg::IDX_W-1:0] r_data;

    // advance one place toward the old end on every beat
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

FILE: src/swmf_hist.sv
module swmf_hist (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  swmf_pkg::t_hist_upd             i_upd,
    output logic [swmf_pkg::IDX_W-1:0]      o_mode
);

    logic [swmf_pkg::CNT_W-1:0] r_count [swmf_pkg::NUM_VALUES];
    logic [swmf_pkg::CNT_W-1:0] n_count [swmf_pkg::NUM_VALUES];

    always_comb begin
        logic dec;
        logic inc;
        for (int v = 0; v < swmf_pkg::NUM_VALUES; v++) begin
            dec = i_upd.drop && (i_upd.old_val == swmf_pkg::IDX_W'(v))
                  && (r_count[v] != '0);
            inc = (i_upd.new_val == swmf_pkg::IDX_W'(v));
            n_count[v] = r_count[v] - swmf_pkg::CNT_W'(dec) + swmf_pkg::CNT_W'(inc);
        end
    end

    // strict compare keeps the lowest value on a tie
    always_comb begin
        logic [swmf_pkg::CNT_W-1:0] best_cnt;
        best_cnt = n_count[0];
        o_mode   = '0;
        for (int v = 1; v < swmf_pkg::NUM_VALUES; v++) begin
            if (n_count[v] > best_cnt) begin
                best_cnt = n_count[v];
                o_mode   = swmf_pkg::IDX_W'(v);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < swmf_pkg::NUM_VALUES; v++) begin
                r_count[v] <= '0;
            end
        end else if (i_upd.en) begin
            for (int v = 0; v < swmf_pkg::NUM_VALUES; v++) begin
                r_count[v] <= n_count[v];
            end
        end
    end

endmodule

FILE: src/sliding_window_mode_filter.sv
// Sliding-window mode filter. Each input beat carries one sample (values above
// five are clamped to five); each beat yields one output beat with the most
// frequent value among the last window_len samples, lowest value on a tie.
// Throughput is one beat per clock unless the sink stalls: samples move through
// a row of 32 shift cells, the cell at the current fill level supplies the
// sample that leaves, and six histogram counters plus a six-way compare settle
// the mode in the same cycle for the output register. Input ready drops only
// while that register is full and the sink stalls. window_len must be written
// only while idle; the block does not enforce it. 0 acts as 1 and values above
// 32 act as 32. After a shrink the fill level holds: each beat drops one old
// sample and adds one, so the mode keeps covering the longer span.
module sliding_window_mode_filter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [swmf_pkg::LEN_W-1:0]      i_cfg_wdata,
    swmf_in_if.sink                         i_in,
    swmf_out_if.source                      o_out
);

    logic [swmf_pkg::LEN_W-1:0]  r_window_len;
    logic [swmf_pkg::CNT_W-1:0]  r_fill;
    logic [swmf_pkg::CNT_W-1:0]  n_fill;
    logic                        r_out_valid;
    logic [swmf_pkg::IDX_W-1:0]  r_mode;

    logic                        w_accept;
    logic [swmf_pkg::CMP_W-1:0]  w_eff_len;
    logic                        w_drop;
    logic [swmf_pkg::IDX_W-1:0]  w_sample;
    logic [swmf_pkg::IDX_W-1:0]  w_mode;
    logic [swmf_pkg::IDX_W-1:0]  w_cell [swmf_pkg::WINDOW_MAX];
    logic [swmf_pkg::PTR_W-1:0]  w_old_idx;
    swmf_pkg::t_hist_upd         w_upd;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        if (i_in.lane_count > swmf_pkg::VAL_W'(swmf_pkg::NUM_VALUES - 1)) begin
            w_sample = swmf_pkg::IDX_W'(swmf_pkg::NUM_VALUES - 1);
        end else begin
            w_sample = swmf_pkg::IDX_W'(i_in.lane_count);
        end
    end

    always_comb begin
        if (r_window_len == '0) begin
            w_eff_len = swmf_pkg::CMP_W'(1);
        end else if (swmf_pkg::CMP_W'(r_window_len) > swmf_pkg::CMP_W'(swmf_pkg::WINDOW_MAX)) begin
            w_eff_len = swmf_pkg::CMP_W'(swmf_pkg::WINDOW_MAX);
        end else begin
            w_eff_len = swmf_pkg::CMP_W'(r_window_len);
        end
    end

    // window full: drop the oldest sample, which sits at cell fill-1
    assign w_drop    = (swmf_pkg::CMP_W'(r_fill) >= w_eff_len) && (r_fill != '0);
    assign w_old_idx = swmf_pkg::PTR_W'(r_fill - swmf_pkg::CNT_W'(1));
    assign n_fill    = r_fill - swmf_pkg::CNT_W'(w_drop) + swmf_pkg::CNT_W'(1);

    generate
        for (genvar k = 0; k < swmf_pkg::WINDOW_MAX; k++) begin : g_cell
            if (k == 0) begin : g_head
                swmf_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (w_accept),
                    .i_data  (w_sample),
                    .o_data  (w_cell[k])
                );
            end else begin : g_body
                swmf_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (w_accept),
                    .i_data  (w_cell[k-1]),
                    .o_data  (w_cell[k])
                );
            end
        end
    endgenerate

    assign w_upd.en      = w_accept;
    assign w_upd.drop    = w_drop;
    assign w_upd.old_val = w_cell[w_old_idx];
    assign w_upd.new_val = w_sample;

    swmf_hist u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (w_upd),
        .o_mode  (w_mode)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= swmf_pkg::LEN_RESET;
        end else if (i_cfg_we) begin
            r_window_len <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= w_mode;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.mode_value = swmf_pkg::VAL_W'(r_mode);

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        swmf_pkg::CMP_W'(r_fill) <= swmf_pkg::CMP_W'(swmf_pkg::WINDOW_MAX))
        else $error("fill level above window capacity");

    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_out_valid && r_fill != '0))
        else $error("accepted beat left no result or empty window");

    a_full_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_fill == swmf_pkg::CNT_W'(swmf_pkg::WINDOW_MAX)) |-> w_drop)
        else $error("full window accepted a beat without eviction");

endmodule

FILE: test/swmf_mode_checker.sv
`timescale 1ns / 100ps
module swmf_mode_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [swmf_pkg::LEN_W-1:0] i_cfg_wdata,
    swmf_in_if                         i_in,
    swmf_out_if                        i_out,
    output int                         o_fail_count,
    output int                         o_pending
);

    localparam int EXP_DEPTH = 64;

    logic [swmf_pkg::VAL_W-1:0] window_samples [swmf_pkg::WINDOW_MAX];
    int unsigned                fill_count;
    int unsigned                oldest_slot;
    int unsigned                value_counts [swmf_pkg::NUM_VALUES];
    logic [swmf_pkg::LEN_W-1:0] window_len;
    logic [swmf_pkg::VAL_W-1:0] expected_modes [EXP_DEPTH];
    int unsigned                exp_head;
    int unsigned                exp_tail;
    int                         exp_count;

    // Push one sample into the window and return the new mode.
    function automatic logic [swmf_pkg::VAL_W-1:0] advance_window(
        input logic [swmf_pkg::VAL_W-1:0] raw
    );
        int unsigned                span;
        int unsigned                sample;
        int unsigned                best;
        logic [swmf_pkg::VAL_W-1:0] leaving;
        sample = (raw > swmf_pkg::NUM_VALUES - 1) ? swmf_pkg::NUM_VALUES - 1 : raw;
        span = (window_len == 0) ? 1 :
               ((window_len > swmf_pkg::WINDOW_MAX) ? swmf_pkg::WINDOW_MAX : window_len);
        // drop the oldest sample once the window is full; one per beat at most
        if (fill_count >= span && fill_count > 0) begin
            leaving = window_samples[oldest_slot];
            if (leaving < swmf_pkg::NUM_VALUES && value_counts[leaving] > 0)
                value_counts[leaving]--;
            oldest_slot = (oldest_slot + 1) % swmf_pkg::WINDOW_MAX;
            fill_count--;
        end
        window_samples[(oldest_slot + fill_count) % swmf_pkg::WINDOW_MAX] =
            swmf_pkg::VAL_W'(sample);
        fill_count++;
        value_counts[sample]++;
        best = 0;
        // strict compare keeps the lowest value on a tie
        for (int v = 1; v < swmf_pkg::NUM_VALUES; v++)
            if (value_counts[v] > value_counts[best])
                best = v;
        return swmf_pkg::VAL_W'(best);
    endfunction

    always @(posedge i_clk) begin
        logic [swmf_pkg::VAL_W-1:0] want;
        if (!i_rst_n) begin
            exp_head     = 0;
            exp_tail     = 0;
            exp_count    = 0;
            fill_count   = 0;
            oldest_slot  = 0;
            window_len   = swmf_pkg::LEN_RESET;
            o_fail_count = 0;
            foreach (value_counts[v])
                value_counts[v] = 0;
            foreach (window_samples[s])
                window_samples[s] = '0;
        end else begin
            if (i_cfg_we)
                window_len = i_cfg_wdata;
            // retire before push: a result never belongs to the beat taken at the same edge
            if (i_out.valid && i_out.ready) begin
                if (exp_count == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: mode beat %0d arrived with nothing expected",
                                 $time, i_out.mode_value);
                    o_fail_count++;
                end else begin
                    want      = expected_modes[exp_head];
                    exp_head  = (exp_head + 1) % EXP_DEPTH;
                    exp_count = exp_count - 1;
                    if (i_out.mode_value !== want) begin
                        if (o_fail_count < 10)
                            $display("%0t: mode_value expected %0d, got %0d",
                                     $time, want, i_out.mode_value);
                        o_fail_count++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                if (exp_count == EXP_DEPTH) begin
                    if (o_fail_count < 10)
                        $display("%0t: more than %0d mode beats outstanding",
                                 $time, EXP_DEPTH);
                    o_fail_count++;
                end else begin
                    expected_modes[exp_tail] = advance_window(i_in.lane_count);
                    exp_tail  = (exp_tail + 1) % EXP_DEPTH;
                    exp_count = exp_count + 1;
                end
            end
        end
        o_pending = exp_count;
    end

endmodule

FILE: test/tb_sliding_window_mode_filter.sv
`timescale 1ns / 100ps
module tb_sliding_window_mode_filter;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 108;
    localparam int HOLD_CYCLES = 80;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    logic [swmf_pkg::LEN_W-1:0] cfg_wdata;
    int                         fail_count;
    int                         pending;
    int                         tx_gap_max = 0;
    int                         rx_gap_max = 0;
    int                         rx_hold = 0;

    swmf_in_if  in_ch ();
    swmf_out_if out_ch ();

    sliding_window_mode_filter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    swmf_mode_checker mode_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic send_sample(input logic [swmf_pkg::VAL_W-1:0] sample);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.lane_count <= sample;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    // Wait for every mode beat, then write the window length while idle.
    task automatic set_window_len(input logic [swmf_pkg::LEN_W-1:0] len);
        in_ch.valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Result side: random stalls, or one long hold when asked.
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (rx_hold > 0) begin
                stall   = rx_hold;
                rx_hold = 0;
            end else begin
                stall = $urandom_range(0, rx_gap_max);
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            @(negedge clk);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_sliding_window_mode_filter failed");
        $finish;
    end

    initial begin
        logic [swmf_pkg::VAL_W-1:0] opening [10];
        logic [swmf_pkg::LEN_W-1:0] phase_lens [12];
        logic [swmf_pkg::VAL_W-1:0] favored;
        opening          = '{0, 1, 2, 3, 4, 5, 6, 7, 7, 1};
        phase_lens       = '{32, 1, 63, 3, 0, 33, 20, 2, 16, 31, 7, 5};
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        in_ch.valid      = 1'b0;
        in_ch.lane_count = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset length: every code, low value wins ties, six and seven clamp to five
        foreach (opening[k])
            send_sample(opening[k]);
        // zero acts as one: the mode follows each sample
        set_window_len(swmf_pkg::LEN_W'(0));
        send_sample(swmf_pkg::VAL_W'(4));
        send_sample(swmf_pkg::VAL_W'(6));
        // above the store depth acts as the full store
        set_window_len(swmf_pkg::LEN_W'(63));
        send_sample(swmf_pkg::VAL_W'(3));
        send_sample(swmf_pkg::VAL_W'(3));
        send_sample(swmf_pkg::VAL_W'(0));
        set_window_len(swmf_pkg::LEN_W'(1));
        send_sample(swmf_pkg::VAL_W'(2));

        for (int p = 0; p < 12; p++) begin
            set_window_len(phase_lens[p]);
            tx_gap_max = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 12 : 3);
            rx_gap_max = (p % 4 == 0) ? 0 : ((p % 4 == 2) ? 12 : 2);
            favored    = swmf_pkg::VAL_W'($urandom_range(0, 7));
            // lean on one value so the mode holds for a while, then gets overtaken
            repeat (PHASE_ITEMS)
                send_sample($urandom_range(0, 1) ? favored :
                            swmf_pkg::VAL_W'($urandom_range(0, 7)));
        end

        // back up the output: hold the sink while beats keep coming
        set_window_len(swmf_pkg::LEN_W'(4));
        tx_gap_max = 0;
        rx_hold    = HOLD_CYCLES;
        repeat (40)
            send_sample(swmf_pkg::VAL_W'($urandom_range(0, 7)));

        in_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_sliding_window_mode_filter passed");
        else
            $display("tb_sliding_window_mode_filter failed");
        $finish;
    end

endmodule

FILE: files.f
src/swmf_pkg.sv
src/swmf_in_if.sv
src/swmf_out_if.sv
src/swmf_cell.sv
src/swmf_hist.sv
src/sliding_window_mode_filter.sv
test/swmf_mode_checker.sv
test/tb_sliding_window_mode_filter.sv
